// ===== hw/rtl/cpe_pkg.sv =====
// Shared types and constants for the closest polyline edge block.
// No dependencies; every other RTL file depends on this package.
`default_nettype none
package cpe_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int IDX_W        = 10;
   localparam int COORD_W      = 32;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int SRC_W        = COORD_W + 2;
   localparam int MAG_W        = DIFF_W;
   localparam int PROD_W       = 2 * MAG_W;
   localparam int ACC_W        = PROD_W + 2;
   localparam int DIST_W       = 64;
   localparam int FRAC_W       = 16;
   localparam int T_W          = FRAC_W + 1;

   localparam logic CSR_QUERY_X = 1'b0;
   localparam logic CSR_QUERY_Y = 1'b1;

   typedef enum logic [2:0] {
      OP_PX_DX = 3'd0,
      OP_PY_DY = 3'd1,
      OP_DX_DX = 3'd2,
      OP_DY_DY = 3'd3,
      OP_T_DX  = 3'd4,
      OP_T_DY  = 3'd5,
      OP_EX_EX = 3'd6,
      OP_EY_EY = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quot;
   } div_rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/cpe_if.sv =====
// Valid/ready channel interfaces for vertex requests and nearest-edge responses.
// Depends on cpe_pkg for field widths.
`default_nettype none
interface cpe_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [cpe_pkg::COORD_W-1:0] vertex_x;
   logic signed [cpe_pkg::COORD_W-1:0] vertex_y;
   logic                              final_vertex;
   modport source (output valid, vertex_x, vertex_y, final_vertex, input ready);
   modport sink   (input valid, vertex_x, vertex_y, final_vertex, output ready);
endinterface

interface cpe_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              found;
   logic [cpe_pkg::IDX_W-1:0]          edge_index;
   logic signed [cpe_pkg::COORD_W-1:0] closest_x;
   logic signed [cpe_pkg::COORD_W-1:0] closest_y;
   logic [cpe_pkg::DIST_W-1:0]         distance_sq;
   modport source (output valid, found, edge_index, closest_x, closest_y, distance_sq,
                   input ready);
   modport sink   (input valid, found, edge_index, closest_x, closest_y, distance_sq,
                   output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cpe_mul.sv =====
// Bit-serial shift-add multiplier, unsigned magnitudes, one multiplier bit per cycle.
// Depends on cpe_pkg.
`default_nettype none
module cpe_mul (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [cpe_pkg::MAG_W-1:0] a_mag,
   input  wire logic [cpe_pkg::MAG_W-1:0] b_mag,
   output cpe_pkg::mul_rsp_type           rsp
);
   import cpe_pkg::*;

   localparam int CW = $clog2(MAG_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [PROD_W-1:0] a_ff;
   logic [MAG_W-1:0]  b_ff;
   logic [PROD_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(MAG_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= {{(PROD_W - MAG_W){1'b0}}, a_mag};
         b_ff   <= b_mag;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_ff + (b_ff[0] ? a_ff : '0);
         a_ff   <= a_ff << 1;
         b_ff   <= b_ff >> 1;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/cpe_div.sv =====
// Restoring divider for the projection fraction, one quotient bit per cycle.
// Depends on cpe_pkg; requires 0 < num < den.
`default_nettype none
module cpe_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [cpe_pkg::ACC_W-1:0] num,
   input  wire logic [cpe_pkg::ACC_W-1:0] den,
   output cpe_pkg::div_rsp_type          rsp
);
   import cpe_pkg::*;

   localparam int CW = $clog2(FRAC_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [ACC_W-1:0]  rem_ff;
   logic [ACC_W-1:0]  den_ff;
   logic [FRAC_W-1:0] quot_ff;
   logic [ACC_W-1:0]  shifted;
   logic              fits;

   assign shifted = rem_ff << 1;
   assign fits    = (shifted >= den_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(FRAC_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= num;
         den_ff  <= den;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= fits ? (shifted - den_ff) : shifted;
         quot_ff <= {quot_ff[FRAC_W-2:0], fits};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/closest_polyline_edge.sv =====
// Top level: nearest segment of a streamed polyline to a configured query point.
// Depends on cpe_pkg, cpe_if, cpe_mul and cpe_div.
//
//   channel  dir  payload                                            handshake
//   req_ch   in   vertex_x, vertex_y, final_vertex                   valid/ready
//   rsp_ch   out  found, edge_index, closest_x, closest_y, distance_sq valid/ready
//   csr_*    in   csr_index, csr_data                                csr_we
//
// A vertex that closes a segment makes 8 passes through the shared bit-serial
// multiplier, plus a pass through the divider when the fraction is strictly inside
// (0,1); other vertices use neither. A final vertex then passes through ST_EMIT to
// load the response register.
// Reset is synchronous and clears the query and the polyline state.
// A response waits in its output register; new vertices are taken meanwhile and a
// following final vertex stalls only until that register is free.
`default_nettype none
module closest_polyline_edge (
   input  wire logic                        clock,
   input  wire logic                        reset,
   cpe_req_if.sink                          req_ch,
   cpe_rsp_if.source                        rsp_ch,
   input  wire logic                        csr_we,
   input  wire logic                        csr_index,
   input  wire logic [cpe_pkg::COORD_W-1:0] csr_data
);
   import cpe_pkg::*;

   state_type               state_ff;
   op_type                  op_ff;
   logic                    mul_start_ff;
   logic                    div_start_ff;
   logic                    last_ff;

   logic signed [COORD_W-1:0] query_x_ff, query_y_ff;
   logic signed [COORD_W-1:0] prev_x_ff, prev_y_ff;
   logic signed [COORD_W-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [COORD_W-1:0] qx_ff, qy_ff;
   logic [CNT_W-1:0]          vcount_ff;
   logic [IDX_W-1:0]          seg_idx_ff;
   logic [T_W-1:0]            t_ff;
   logic signed [ACC_W-1:0]   acc_ff, num_ff, den_ff;

   logic                      best_valid_ff;
   logic [IDX_W-1:0]          best_edge_ff;
   logic signed [COORD_W-1:0] best_x_ff, best_y_ff;
   logic [DIST_W-1:0]         best_dist_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_found_ff;
   logic [IDX_W-1:0]          rsp_idx_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [DIST_W-1:0]         rsp_dist_ff;

   mul_rsp_type               mul_rsp;
   div_rsp_type               div_rsp;

   logic signed [SRC_W-1:0]   src_a, src_b;
   logic signed [SRC_W-1:0]   dx, dy, px, py, ex, ey;
   logic [MAG_W-1:0]          mag_a, mag_b;
   logic                      prod_neg;
   logic signed [ACC_W-1:0]   prod_ext, prod_s, prod_shr, sum_in;
   logic [DIST_W-1:0]         dist_in;
   logic                      take, emit_go, has_room;

   assign dx = SRC_W'(bx_ff) - SRC_W'(ax_ff);
   assign dy = SRC_W'(by_ff) - SRC_W'(ay_ff);
   assign px = SRC_W'(query_x_ff) - SRC_W'(ax_ff);
   assign py = SRC_W'(query_y_ff) - SRC_W'(ay_ff);
   assign ex = SRC_W'(query_x_ff) - SRC_W'(qx_ff);
   assign ey = SRC_W'(query_y_ff) - SRC_W'(qy_ff);

   always_comb begin
      case (op_ff)
         OP_PX_DX: begin src_a = px; src_b = dx; end
         OP_PY_DY: begin src_a = py; src_b = dy; end
         OP_DX_DX: begin src_a = dx; src_b = dx; end
         OP_DY_DY: begin src_a = dy; src_b = dy; end
         OP_T_DX:  begin src_a = SRC_W'(t_ff); src_b = dx; end
         OP_T_DY:  begin src_a = SRC_W'(t_ff); src_b = dy; end
         OP_EX_EX: begin src_a = ex; src_b = ex; end
         OP_EY_EY: begin src_a = ey; src_b = ey; end
         default:  begin src_a = '0; src_b = '0; end
      endcase
   end

   assign mag_a    = src_a[SRC_W-1] ? MAG_W'(-src_a) : MAG_W'(src_a);
   assign mag_b    = src_b[SRC_W-1] ? MAG_W'(-src_b) : MAG_W'(src_b);
   assign prod_neg = src_a[SRC_W-1] ^ src_b[SRC_W-1];
   assign prod_ext = signed'({2'b00, mul_rsp.prod});
   assign prod_s   = prod_neg ? -prod_ext : prod_ext;
   assign prod_shr = prod_s >>> FRAC_W;
   assign sum_in   = acc_ff + prod_s;
   assign dist_in  = (|sum_in[ACC_W-1:DIST_W]) ? '1 : sum_in[DIST_W-1:0];

   cpe_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start_ff),
      .a_mag (mag_a),
      .b_mag (mag_b),
      .rsp   (mul_rsp)
   );

   cpe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (num_ff),
      .den   (den_ff),
      .rsp   (div_rsp)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign take         = req_ch.valid && req_ch.ready;
   assign has_room     = !rsp_valid_ff || rsp_ch.ready;
   assign emit_go      = (state_ff == ST_EMIT) && has_room;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_x_ff <= '0;
         query_y_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_QUERY_X: query_x_ff <= signed'(csr_data);
            CSR_QUERY_Y: query_y_ff <= signed'(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_PX_DX;
         mul_start_ff  <= 1'b0;
         div_start_ff  <= 1'b0;
         last_ff       <= 1'b0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         vcount_ff     <= '0;
         best_valid_ff <= 1'b0;
         best_edge_ff  <= '0;
         best_x_ff     <= '0;
         best_y_ff     <= '0;
         best_dist_ff  <= '0;
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  last_ff <= req_ch.final_vertex;
                  if (vcount_ff < CNT_W'(MAX_VERTICES)) begin
                     prev_x_ff <= req_ch.vertex_x;
                     prev_y_ff <= req_ch.vertex_y;
                     vcount_ff <= vcount_ff + 1'b1;
                  end
                  if (vcount_ff < CNT_W'(MAX_VERTICES) && vcount_ff != '0) begin
                     ax_ff        <= prev_x_ff;
                     ay_ff        <= prev_y_ff;
                     bx_ff        <= req_ch.vertex_x;
                     by_ff        <= req_ch.vertex_y;
                     seg_idx_ff   <= IDX_W'(vcount_ff - 1'b1);
                     op_ff        <= OP_PX_DX;
                     mul_start_ff <= 1'b1;
                     state_ff     <= ST_MUL;
                  end else if (req_ch.final_vertex) begin
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_MUL: begin
               if (mul_rsp.done) begin
                  case (op_ff)
                     OP_PX_DX, OP_DX_DX, OP_EX_EX: begin
                        acc_ff       <= prod_s;
                        op_ff        <= op_type'(op_ff + 1'b1);
                        mul_start_ff <= 1'b1;
                     end
                     OP_PY_DY: begin
                        num_ff       <= sum_in;
                        op_ff        <= OP_DX_DX;
                        mul_start_ff <= 1'b1;
                     end
                     OP_DY_DY: begin
                        den_ff <= sum_in;
                        if (num_ff[ACC_W-1] || num_ff == '0) begin
                           t_ff         <= '0;
                           op_ff        <= OP_T_DX;
                           mul_start_ff <= 1'b1;
                        end else if (num_ff >= sum_in) begin
                           t_ff         <= T_W'(1) << FRAC_W;
                           op_ff        <= OP_T_DX;
                           mul_start_ff <= 1'b1;
                        end else begin
                           div_start_ff <= 1'b1;
                           state_ff     <= ST_DIV;
                        end
                     end
                     OP_T_DX: begin
                        qx_ff        <= ax_ff + prod_shr[COORD_W-1:0];
                        op_ff        <= OP_T_DY;
                        mul_start_ff <= 1'b1;
                     end
                     OP_T_DY: begin
                        qy_ff        <= ay_ff + prod_shr[COORD_W-1:0];
                        op_ff        <= OP_EX_EX;
                        mul_start_ff <= 1'b1;
                     end
                     OP_EY_EY: begin
                        if (!best_valid_ff || dist_in < best_dist_ff) begin
                           best_valid_ff <= 1'b1;
                           best_edge_ff  <= seg_idx_ff;
                           best_x_ff     <= qx_ff;
                           best_y_ff     <= qy_ff;
                           best_dist_ff  <= dist_in;
                        end
                        state_ff <= last_ff ? ST_EMIT : ST_IDLE;
                     end
                     default: ;
                  endcase
               end
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  t_ff         <= {1'b0, div_rsp.quot};
                  op_ff        <= OP_T_DX;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_MUL;
               end
            end
            ST_EMIT: begin
               if (has_room) begin
                  prev_x_ff     <= '0;
                  prev_y_ff     <= '0;
                  vcount_ff     <= '0;
                  best_valid_ff <= 1'b0;
                  best_edge_ff  <= '0;
                  best_x_ff     <= '0;
                  best_y_ff     <= '0;
                  best_dist_ff  <= '0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_found_ff <= best_valid_ff;
         rsp_idx_ff   <= best_edge_ff;
         rsp_x_ff     <= best_x_ff;
         rsp_y_ff     <= best_y_ff;
         rsp_dist_ff  <= best_dist_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.edge_index  = rsp_idx_ff;
   assign rsp_ch.closest_x   = rsp_x_ff;
   assign rsp_ch.closest_y   = rsp_y_ff;
   assign rsp_ch.distance_sq = rsp_dist_ff;

   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (!num_ff[ACC_W-1] && num_ff != '0 && num_ff < den_ff))
      else $error("divider running outside (0,1)");

   a_best_needs_segment: assert property (@(posedge clock) disable iff (reset)
      best_valid_ff |-> (vcount_ff >= CNT_W'(2)))
      else $error("best segment kept with fewer than two vertices");

   a_clear_on_emit: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> (vcount_ff == '0 && !best_valid_ff && rsp_valid_ff))
      else $error("polyline state not cleared after response");
endmodule
`default_nettype wire

// ===== tb/closest_polyline_edge_checker.sv =====
// Checker for closest_polyline_edge: watches the vertex and response channels,
// predicts each nearest-edge response and compares it field by field.
// Depends on cpe_pkg and cpe_if.
module closest_polyline_edge_checker (
   input  logic        clock,
   input  logic        reset,
   cpe_req_if.sink     req_mon,
   cpe_rsp_if.sink     rsp_mon,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import cpe_pkg::*;

   typedef struct packed {
      logic              found;
      logic [IDX_W-1:0]  edge_index;
      logic [31:0]       closest_x;
      logic [31:0]       closest_y;
      logic [63:0]       distance_sq;
   } edge_result_type;

   edge_result_type nearest_q[$];

   logic signed [31:0] qry_x, qry_y;
   logic signed [31:0] last_x, last_y;
   int unsigned        nvert;
   logic               have_best;
   logic [IDX_W-1:0]   keep_idx;
   logic signed [31:0] best_px, best_py;
   logic [63:0]        best_d;

   assign pending_count = nearest_q.size();

   function automatic logic signed [33:0] floor_frac(input logic signed [50:0] v);
      return 34'(v >>> 16);
   endfunction

   task automatic fold_segment(input logic signed [31:0] ax, input logic signed [31:0] ay,
                               input logic signed [31:0] bx, input logic signed [31:0] by,
                               input int unsigned idx);
      logic signed [33:0]  dx, dy, px, py, cx, cy, ex, ey;
      logic signed [69:0]  num, den;
      logic [16:0]         t;
      logic [64:0]         sum;
      logic [63:0]         dist_sq, sx, sy;
      dx = 34'(bx) - 34'(ax);
      dy = 34'(by) - 34'(ay);
      cx = 34'(ax);
      cy = 34'(ay);
      if (dx != 0 || dy != 0) begin
         px = 34'(qry_x) - 34'(ax);
         py = 34'(qry_y) - 34'(ay);
         num = 70'(px) * 70'(dx) + 70'(py) * 70'(dy);
         den = 70'(dx) * 70'(dx) + 70'(dy) * 70'(dy);
         if (num <= 0) t = 0;
         else if (num >= den) t = 17'd65536;
         else t = 17'((90'(num) <<< 16) / 90'(den));
         cx = 34'(ax) + floor_frac(51'($signed({1'b0, t})) * 51'(dx));
         cy = 34'(ay) + floor_frac(51'($signed({1'b0, t})) * 51'(dy));
      end
      ex = 34'(qry_x) - cx;
      ey = 34'(qry_y) - cy;
      sx = 64'(68'(ex) * 68'(ex));
      sy = 64'(68'(ey) * 68'(ey));
      sum = {1'b0, sx} + {1'b0, sy};
      dist_sq = sum[64] ? '1 : sum[63:0];
      if (!have_best || dist_sq < best_d) begin
         have_best = 1'b1;
         keep_idx  = IDX_W'(idx);
         best_px   = cx[31:0];
         best_py   = cy[31:0];
         best_d    = dist_sq;
      end
   endtask

   task automatic clear_line();
      last_x = 0; last_y = 0; nvert = 0;
      have_best = 0; keep_idx = 0; best_px = 0; best_py = 0; best_d = 0;
   endtask

   task automatic take_vertex(input logic signed [31:0] vx, input logic signed [31:0] vy,
                              input logic fin);
      edge_result_type r;
      if (nvert < MAX_VERTICES) begin
         if (nvert > 0) fold_segment(last_x, last_y, vx, vy, nvert - 1);
         last_x = vx;
         last_y = vy;
         nvert++;
      end
      if (fin) begin
         r = '0;
         if (have_best) r = '{1'b1, keep_idx, best_px, best_py, best_d};
         nearest_q = {nearest_q, r};
         clear_line();
      end
   endtask

   always @(posedge clock) begin
      edge_result_type e;
      if (reset) begin
         qry_x = 0; qry_y = 0;
         clear_line();
         nearest_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_QUERY_X) qry_x = csr_data;
            else qry_y = csr_data;
         end
         if (req_mon.valid && req_mon.ready)
            take_vertex(req_mon.vertex_x, req_mon.vertex_y, req_mon.final_vertex);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (nearest_q.size() == 0) begin
               $error("response transfer with nothing expected");
               fail_count++;
            end else begin
               e = nearest_q.pop_front();
               if (rsp_mon.found !== e.found) begin
                  $error("found exp %0d got %0d", e.found, rsp_mon.found); fail_count++;
               end
               if (rsp_mon.edge_index !== e.edge_index) begin
                  $error("edge_index exp %0d got %0d", e.edge_index, rsp_mon.edge_index);
                  fail_count++;
               end
               if (rsp_mon.closest_x !== e.closest_x) begin
                  $error("closest_x exp %h got %h", e.closest_x, rsp_mon.closest_x);
                  fail_count++;
               end
               if (rsp_mon.closest_y !== e.closest_y) begin
                  $error("closest_y exp %h got %h", e.closest_y, rsp_mon.closest_y);
                  fail_count++;
               end
               if (rsp_mon.distance_sq !== e.distance_sq) begin
                  $error("distance_sq exp %h got %h", e.distance_sq, rsp_mon.distance_sq);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

// ===== tb/closest_polyline_edge_tb.sv =====
// Testbench top for closest_polyline_edge: drives polylines and query writes,
// applies backpressure and gives the verdict. Depends on cpe_pkg, cpe_if, the checker.
module closest_polyline_edge_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cpe_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic        csr_index = CSR_QUERY_X;
   logic [31:0] csr_data = 0;
   int          fail_count, pending_count;
   int          idle_cycles = 0;
   bit          no_idle = 0;
   bit          hold_rsp = 0;
   int          sent = 0;

   cpe_req_if req_ch ();
   cpe_rsp_if rsp_ch ();

   closest_polyline_edge dut (
      .clock, .reset, .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we, .csr_index, .csr_data
   );

   closest_polyline_edge_checker chk (
      .clock, .reset, .req_mon(req_ch.sink), .rsp_mon(rsp_ch.sink),
      .csr_we, .csr_index, .csr_data, .fail_count, .pending_count
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.vertex_x = 0;
      req_ch.vertex_y = 0;
      req_ch.final_vertex = 0;
      rsp_ch.ready = 0;
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int n;
      @(negedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 0;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 16);
            rsp_ch.ready <= 0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [31:0] pick_coord(input int mode);
      case (mode)
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom;
         default: return 32'($signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000);
      endcase
   endfunction

   // valid stays high between back-to-back transfers; idle gaps and drain() drop it
   task automatic push_vertex(input logic [31:0] vx, input logic [31:0] vy,
                              input logic fin);
      int n;
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 16);
         req_ch.valid <= 0;
         repeat (n) @(negedge clock);
      end
      req_ch.valid        <= 1;
      req_ch.vertex_x     <= vx;
      req_ch.vertex_y     <= vy;
      req_ch.final_vertex <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic write_query(input logic [31:0] qx, input logic [31:0] qy);
      csr_we <= 1; csr_index <= CSR_QUERY_X; csr_data <= qx;
      @(negedge clock);
      csr_index <= CSR_QUERY_Y; csr_data <= qy;
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic random_polyline(input int len, input int mode);
      for (int i = 0; i < len; i++)
         push_vertex(pick_coord(mode), pick_coord(mode), i == len - 1);
   endtask

   initial begin
      int len;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: single vertex, zero-length, tie, extremes
      push_vertex(32'h0001_0000, 32'h0, 1);
      push_vertex(32'h0002_0000, 32'h0002_0000, 0);
      push_vertex(32'h0002_0000, 32'h0002_0000, 1);
      push_vertex(32'hffff_0000, 32'h0001_0000, 0);
      push_vertex(32'h0001_0000, 32'h0001_0000, 0);
      push_vertex(32'h0001_0000, 32'hffff_0000, 0);
      push_vertex(32'hffff_0000, 32'hffff_0000, 1);
      push_vertex(32'h8000_0000, 32'h8000_0000, 0);
      push_vertex(32'h7fff_ffff, 32'h7fff_ffff, 0);
      push_vertex(32'h8000_0000, 32'h7fff_ffff, 1);
      drain();
      write_query(32'h7fff_ffff, 32'h8000_0000);
      push_vertex(32'h8000_0000, 32'h7fff_ffff, 0);
      push_vertex(32'h8000_0000, 32'h8000_0000, 0);
      push_vertex(32'h0000_1234, 32'hffff_0001, 0);
      push_vertex(32'h7fff_ffff, 32'h7fff_ffff, 1);
      drain();
      write_query(32'h0000_8000, 32'hffff_c000);
      push_vertex(32'h0, 32'h0, 0);
      push_vertex(32'h0001_0000, 32'h0, 0);
      push_vertex(32'h0001_0000, 32'h0, 0);
      push_vertex(32'h0, 32'h0, 1);
      // long receiver hold-off while vertices keep coming
      hold_rsp = 1;
      for (int p = 0; p < 6; p++) random_polyline(2, 3);
      drain();
      // random phases with new queries between them
      for (int ph = 0; ph < 6; ph++) begin
         write_query(pick_coord(ph % 4), pick_coord((ph + 2) % 4));
         if (ph == 5) no_idle = 1;
         for (int p = 0; p < 25; p++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) + 1
                                               : $urandom_range(2, 5);
            random_polyline(len, $urandom_range(0, 9) < 2 ? $urandom_range(0, 2) : 3);
         end
         drain();
      end
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/cpe_pkg.sv
hw/rtl/cpe_if.sv
hw/rtl/cpe_mul.sv
hw/rtl/cpe_div.sv
hw/rtl/closest_polyline_edge.sv
tb/closest_polyline_edge_checker.sv
tb/closest_polyline_edge_tb.sv
